// ===== rtl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// shared widths, command codes and word types of the calendar date adder
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam int YEAR_W   = 16;
    localparam int AMOUNT_W = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int KIND_W   = 2;
    // year mod 400 fits in 9 bits
    localparam int Y400_W   = 9;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DAYS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MONTHS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_YEARS  = 2'd3;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [YEAR_W-1:0]   load_year;
        logic [MONTH_W-1:0]  load_month;
        logic [DAY_W-1:0]    load_day;
        logic [AMOUNT_W-1:0] amount;
    } cmd_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [DAY_W-1:0]   out_day;
    } result_t;

endpackage

// ===== rtl/cda_mlen.sv =====
// ----------------------------------------------------------------------------
// cda_mlen
// leap-year test from the year mod 400 and the length of the given month
// ----------------------------------------------------------------------------
module cda_mlen (
    input  logic [cda_pkg::MONTH_W-1:0] month,
    input  logic [cda_pkg::Y400_W-1:0]  y400,
    output logic                        leap,
    output logic [cda_pkg::DAY_W-1:0]   len
);
    import cda_pkg::*;

    logic century;

    // inside one 400-year cycle the century years are 0, 100, 200, 300
    assign century = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
    assign leap    = (y400[1:0] == 2'b00) && !century;

    always_comb
    begin
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
    end

endmodule

// ===== rtl/calendar_date_adder_top.sv =====
// ----------------------------------------------------------------------------
// calendar_date_adder_top
// keeps a gregorian date and loads it or adds days, months or years to it
// ----------------------------------------------------------------------------
// latency from accept to done depends on the states passed: loads and year adds pass
// S_YDIV, S_YREM and S_CLAMP, month adds pass S_MDIV and S_MFIX before these, and
// day adds walk month by month in S_WALK and skip whole years from january 1st;
// the walk loop and the shared reciprocal multiplier set it
// one word at a time: busy stays high until the result strobe; results cannot stall
// reset gives 2020-01-15 and an idle block
module calendar_date_adder_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cda_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output cda_pkg::result_t result
);
    import cda_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_MDIV  = 3'd2;
    localparam logic [2:0] S_MFIX  = 3'd3;
    localparam logic [2:0] S_YDIV  = 3'd4;
    localparam logic [2:0] S_YREM  = 3'd5;
    localparam logic [2:0] S_CLAMP = 3'd6;

    localparam int TOTAL_W = AMOUNT_W + 1;
    localparam int PROD_W  = 2 * TOTAL_W;
    // floor(x / 12) = (x * 87382) >> 20 and floor(y / 400) = (y * 83887) >> 25
    localparam logic [TOTAL_W-1:0] RECIP12  = 17'd87382;
    localparam logic [TOTAL_W-1:0] RECIP400 = 17'd83887;
    localparam int SHIFT12  = 20;
    localparam int SHIFT400 = 25;

    logic [2:0]          state_reg, state_next;
    logic                done_reg, done_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [Y400_W-1:0]   y400_reg, y400_next;
    logic [AMOUNT_W-1:0] left_reg, left_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [PROD_W-1:0]   prod_reg;

    logic [TOTAL_W-1:0]  mul_a, mul_b;
    logic                leap;
    logic [DAY_W-1:0]    len;
    logic [8:0]          ylen;
    logic [TOTAL_W-1:0]  day_sum;
    logic [AMOUNT_W-1:0] step;
    logic [12:0]         q12;
    logic [8:0]          q400;
    logic [YEAR_W-1:0]   y_rem;
    logic [TOTAL_W-1:0]  m_rem;
    logic [MONTH_W-1:0]  load_m;
    logic [Y400_W-1:0]   y400_inc;

    cda_mlen u_mlen (
        .month (month_reg),
        .y400  (y400_reg),
        .leap  (leap),
        .len   (len)
    );

    // shared multiplier for both reciprocal divisions
    assign mul_a = (state_reg == S_MDIV) ? total_reg : {1'b0, year_reg};
    assign mul_b = (state_reg == S_MDIV) ? RECIP12 : RECIP400;

    assign ylen    = leap ? 9'd366 : 9'd365;
    assign day_sum = {{(TOTAL_W-DAY_W){1'b0}}, day_reg} + {1'b0, left_reg};
    assign step    = {{(AMOUNT_W-DAY_W){1'b0}}, len} - {{(AMOUNT_W-DAY_W){1'b0}}, day_reg}
                     + {{(AMOUNT_W-1){1'b0}}, 1'b1};

    assign q12  = prod_reg[SHIFT12+12:SHIFT12];
    assign q400 = prod_reg[SHIFT400+8:SHIFT400];
    assign m_rem = total_reg - ({q12, 4'b0000} - {2'b00, q12, 2'b00});
    assign y_rem = year_reg - ({q400[7:0], 8'b0} + {1'b0, q400[7:0], 7'b0}
                   + {4'b0, q400[7:0], 4'b0});

    assign load_m = (cmd.load_month == 4'd0) ? MONTH_JAN :
                    (cmd.load_month > MONTH_DEC) ? MONTH_DEC : cmd.load_month;

    // year 65535 wraps to 0, which restarts the 400-year cycle
    assign y400_inc = ((y400_reg == 9'd399) || (year_reg == {YEAR_W{1'b1}})) ? 9'd0
                      : y400_reg + 9'd1;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        y400_next  = y400_reg;
        left_next  = left_reg;
        total_next = total_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.kind)
                        KIND_LOAD:
                        begin
                            year_next  = cmd.load_year;
                            month_next = load_m;
                            day_next   = cmd.load_day;
                            state_next = S_YDIV;
                        end
                        KIND_DAYS:
                        begin
                            left_next  = cmd.amount;
                            state_next = S_WALK;
                        end
                        KIND_MONTHS:
                        begin
                            total_next = {{(TOTAL_W-MONTH_W){1'b0}}, month_reg - 4'd1}
                                         + {1'b0, cmd.amount};
                            state_next = S_MDIV;
                        end
                        default:
                        begin
                            year_next  = year_reg + cmd.amount;
                            state_next = S_YDIV;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if ((month_reg == MONTH_JAN) && (day_reg == 5'd1)
                    && (left_reg >= {{(AMOUNT_W-9){1'b0}}, ylen}))
                begin
                    // skip a whole year from january 1st
                    left_next = left_reg - {{(AMOUNT_W-9){1'b0}}, ylen};
                    year_next = year_reg + {{(YEAR_W-1){1'b0}}, 1'b1};
                    y400_next = y400_inc;
                end
                else if (day_sum <= {{(TOTAL_W-DAY_W){1'b0}}, len})
                begin
                    day_next   = day_sum[DAY_W-1:0];
                    left_next  = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    left_next = left_reg - step;
                    day_next  = 5'd1;
                    if (month_reg >= MONTH_DEC)
                    begin
                        month_next = MONTH_JAN;
                        year_next  = year_reg + {{(YEAR_W-1){1'b0}}, 1'b1};
                        y400_next  = y400_inc;
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
            end
            S_MDIV:
            begin
                state_next = S_MFIX;
            end
            S_MFIX:
            begin
                year_next  = year_reg + {{(YEAR_W-13){1'b0}}, q12};
                month_next = m_rem[MONTH_W-1:0] + 4'd1;
                state_next = S_YDIV;
            end
            S_YDIV:
            begin
                state_next = S_YREM;
            end
            S_YREM:
            begin
                y400_next  = y_rem[Y400_W-1:0];
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (day_reg == 5'd0)
                    day_next = 5'd1;
                else if (day_reg > len)
                    day_next = len;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            year_reg  <= 16'd2020;
            month_reg <= MONTH_JAN;
            day_reg   <= 5'd15;
            y400_reg  <= 9'd20;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            y400_reg  <= y400_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        prod_reg  <= mul_a * mul_b;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign result.out_year  = year_reg;
    assign result.out_month = month_reg;
    assign result.out_day   = day_reg;

endmodule

// ===== test/tb_calendar_date_adder_top.sv =====
// ----------------------------------------------------------------------------
// tb_calendar_date_adder_top
// self-checking bench for the calendar date adder: directed date corners,
// then a random mix of loads and day, month and year adds; every result word
// is compared field by field against a software date calculator
// ----------------------------------------------------------------------------
module tb_calendar_date_adder_top;

    import cda_pkg::*;

    localparam int IDLE_LIMIT   = 10000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_WORDS = 245;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    // predicted date, kept in step with every accepted command
    logic [YEAR_W-1:0]  date_year = 16'd2020;
    logic [MONTH_W-1:0] date_month = 4'd1;
    logic [DAY_W-1:0]   date_day = 5'd15;

    result_t expected_dates [$];
    result_t want;
    int      error_count = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;

    calendar_date_adder_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_leap_year(input logic [YEAR_W-1:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(input logic [YEAR_W-1:0] y,
                                               input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] mm;
        mm = (m < 1 || m > 12) ? MONTH_DEC : m;
        if (mm == MONTH_FEB)
            return is_leap_year(y) ? 29 : 28;
        case (mm)
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            default:                 return 31;
        endcase
    endfunction

    // applies one command to the predicted date and returns the new date
    function automatic result_t advance_date(input cmd_t c);
        int unsigned left;
        int unsigned total;
        int unsigned len;
        bit          walking;
        result_t     r;
        case (c.kind)
            KIND_LOAD:
            begin
                date_year = c.load_year;
                if (c.load_month < 1)
                    date_month = MONTH_JAN;
                else if (c.load_month > 12)
                    date_month = MONTH_DEC;
                else
                    date_month = c.load_month;
                date_day = c.load_day;
            end
            KIND_DAYS:
            begin
                left = 32'(c.amount);
                walking = 1'b1;
                while (walking)
                begin
                    len = month_days(date_year, date_month);
                    if (date_day + left <= len)
                    begin
                        date_day = DAY_W'(date_day + left);
                        walking = 1'b0;
                    end
                    else
                    begin
                        left = left - (len - date_day + 1);
                        date_day = 5'd1;
                        if (date_month >= MONTH_DEC)
                        begin
                            date_month = MONTH_JAN;
                            date_year = date_year + 16'd1;
                        end
                        else
                        begin
                            date_month = date_month + 4'd1;
                        end
                        // whole years skipped from january 1st
                        while (date_month == MONTH_JAN &&
                               left >= (is_leap_year(date_year) ? 366 : 365))
                        begin
                            left = left - (is_leap_year(date_year) ? 366 : 365);
                            date_year = date_year + 16'd1;
                        end
                    end
                end
            end
            KIND_MONTHS:
            begin
                total = (date_month - 1) + c.amount;
                date_year = date_year + YEAR_W'(total / 12);
                date_month = MONTH_W'(total % 12 + 1);
            end
            default:
            begin
                date_year = date_year + c.amount;
            end
        endcase
        len = month_days(date_year, date_month);
        if (date_day < 1)
            date_day = 5'd1;
        if (date_day > len)
            date_day = DAY_W'(len);
        r.out_year = date_year;
        r.out_month = date_month;
        r.out_day = date_day;
        return r;
    endfunction

    function automatic cmd_t make_cmd(input logic [KIND_W-1:0] kind,
                                      input logic [YEAR_W-1:0] year,
                                      input logic [MONTH_W-1:0] month,
                                      input logic [DAY_W-1:0] day,
                                      input logic [AMOUNT_W-1:0] amount);
        cmd_t c;
        c.kind = kind;
        c.load_year = year;
        c.load_month = month;
        c.load_day = day;
        c.amount = amount;
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        $display("mismatch %s: got %0d, expected %0d", what, got, exp_val);
        error_count++;
    endtask

    // sends one command word; start stays high afterwards unless a gap follows
    task automatic send_cmd(input cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_dates.push_back(advance_date(c));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_dates.size() == 0)
            begin
                report_mismatch("result word with no command pending", result.out_year, 0);
            end
            else
            begin
                want = expected_dates.pop_front();
                if (result.out_year !== want.out_year)
                    report_mismatch("out_year", result.out_year, want.out_year);
                if (result.out_month !== want.out_month)
                    report_mismatch("out_month", result.out_month, want.out_month);
                if (result.out_day !== want.out_day)
                    report_mismatch("out_day", result.out_day, want.out_day);
            end
        end
    end

    // counts cycles with no word moving in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_reset_date();
        send_cmd(make_cmd(KIND_DAYS, 0, 0, 0, 0));
    endtask

    task automatic test_load_clamping();
        send_cmd(make_cmd(KIND_LOAD, 16'd0, 4'd0, 5'd0, 0));
        send_cmd(make_cmd(KIND_LOAD, 16'hffff, 4'd15, 5'd31, 16'hffff));
        send_cmd(make_cmd(KIND_LOAD, 16'd1, 4'd13, 5'd31, 0));
        send_cmd(make_cmd(KIND_LOAD, 16'd2024, MONTH_FEB, 5'd31, 0));
        send_cmd(make_cmd(KIND_LOAD, 16'd1900, MONTH_FEB, 5'd29, 0));
        send_cmd(make_cmd(KIND_LOAD, 16'd2023, 4'd4, 5'd31, 0));
        send_cmd(make_cmd(KIND_LOAD, 16'd0, MONTH_FEB, 5'd30, 0));
    endtask

    task automatic test_day_walk();
        send_cmd(make_cmd(KIND_LOAD, 16'hffff, MONTH_DEC, 5'd31, 0));
        send_cmd(make_cmd(KIND_DAYS, 0, 0, 0, 16'd1));
        send_cmd(make_cmd(KIND_LOAD, 16'd2000, MONTH_FEB, 5'd28, 0));
        send_cmd(make_cmd(KIND_DAYS, 0, 0, 0, 16'd1));
        send_cmd(make_cmd(KIND_DAYS, 0, 0, 0, 16'd1));
        send_cmd(make_cmd(KIND_LOAD, 16'd2099, MONTH_JAN, 5'd1, 0));
        send_cmd(make_cmd(KIND_DAYS, 0, 0, 0, 16'd365));
        send_cmd(make_cmd(KIND_DAYS, 0, 0, 0, 16'hffff));
    endtask

    task automatic test_month_add();
        send_cmd(make_cmd(KIND_LOAD, 16'd2020, MONTH_JAN, 5'd31, 0));
        send_cmd(make_cmd(KIND_MONTHS, 0, 0, 0, 16'd1));
        send_cmd(make_cmd(KIND_MONTHS, 0, 0, 0, 16'd12));
        send_cmd(make_cmd(KIND_MONTHS, 0, 0, 0, 16'd0));
        send_cmd(make_cmd(KIND_MONTHS, 0, 0, 0, 16'hffff));
    endtask

    task automatic test_year_add();
        send_cmd(make_cmd(KIND_LOAD, 16'd2024, MONTH_FEB, 5'd29, 0));
        send_cmd(make_cmd(KIND_YEARS, 0, 0, 0, 16'd1));
        send_cmd(make_cmd(KIND_YEARS, 0, 0, 0, 16'd0));
        send_cmd(make_cmd(KIND_YEARS, 0, 0, 0, 16'hffff));
    endtask

    task automatic test_random_mix();
        cmd_t c;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // loads about a quarter of the time, the adds share the rest
            case ($urandom_range(0, 3))
                0:       c.kind = KIND_LOAD;
                1:       c.kind = KIND_DAYS;
                2:       c.kind = KIND_MONTHS;
                default: c.kind = KIND_YEARS;
            endcase
            if ($urandom_range(0, 3) == 0)
                c.load_year = YEAR_W'($urandom_range(0, 655) * 100);
            else
                c.load_year = YEAR_W'($urandom);
            c.load_month = MONTH_W'($urandom_range(0, 15));
            if ($urandom_range(0, 2) == 0)
                c.load_day = DAY_W'($urandom_range(28, 31));
            else
                c.load_day = DAY_W'($urandom_range(0, 31));
            case ($urandom_range(0, 7))
                0:       c.amount = AMOUNT_W'($urandom);
                1:       c.amount = '0;
                default: c.amount = AMOUNT_W'($urandom_range(1, 800));
            endcase
            send_cmd(c);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_date();
        test_load_clamping();
        test_day_walk();
        test_month_add();
        test_year_add();
        test_random_mix();
        start <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== calendar_date_adder_top.f =====
rtl/cda_pkg.sv
rtl/cda_mlen.sv
rtl/calendar_date_adder_top.sv
test/tb_calendar_date_adder_top.sv
